FILE: design/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants of the timeline playhead advance block.
// ----------------------------------------------------------------------------
`default_nettype none
package tpa_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_DRY,
      ST_EMIT,
      ST_SINGLE
   } state_type;

   typedef enum logic [2:0] {
      MD_IDLE,
      MD_MUL,
      MD_SUM,
      MD_ABS,
      MD_DIV
   } md_state_type;

   typedef struct packed {
      logic [63:0] quot;
      logic        neg;
      logic [31:0] rem;
   } md_result_type;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_NEG = 2'd1;
   localparam logic [1:0] STATUS_CAP = 2'd2;

   localparam logic [1:0] MODE_LOOP     = 2'd1;
   localparam logic [1:0] MODE_PINGPONG = 2'd2;

   localparam logic [2:0] REG_DURATION  = 3'd0;
   localparam logic [2:0] REG_LOOP_MODE = 3'd1;
   localparam logic [2:0] REG_MAX_CROSS = 3'd2;
   localparam logic [2:0] REG_RATE_NUM  = 3'd3;
   localparam logic [2:0] REG_RATE_DEN  = 3'd4;
   localparam logic [2:0] REG_START_POS = 3'd5;
   localparam logic [2:0] REG_SUPPRESS  = 3'd6;

endpackage
`default_nettype wire

FILE: design/tpa_muldiv.sv
// ----------------------------------------------------------------------------
// tpa_muldiv
// Bit-serial rate scaling: delta times numerator plus carried remainder,
// then a restoring division by the denominator, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module tpa_muldiv (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [31:0]            delta,
   input  wire logic [31:0]            num,
   input  wire logic [31:0]            rem_in,
   input  wire logic [30:0]            den,
   output logic                        done,
   output tpa_pkg::md_result_type      result
);

   tpa_pkg::md_state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [31:0] r_ff, r_in;
   logic        done_ff, done_in;

   logic [32:0] psum;
   logic [31:0] trial;
   logic [31:0] den_eff;
   logic        ge;

   always_comb begin
      den_eff = (den == 31'd0) ? 32'd1 : {1'b0, den};
      psum    = lo_ff[0] ? (hi_ff + {num[31], num}) : hi_ff;
      trial   = {r_ff[30:0], acc_ff[63]};
      ge      = trial >= den_eff;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      r_in     = r_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         tpa_pkg::MD_IDLE: begin
            if (start) begin
               hi_in    = '0;
               lo_in    = delta;
               cnt_in   = '0;
               state_in = tpa_pkg::MD_MUL;
            end
         end
         tpa_pkg::MD_MUL: begin
            // Shift-add: the multiplier bits leave the low half as the product enters.
            hi_in  = {psum[32], psum[32:1]};
            lo_in  = {psum[0], lo_ff[31:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = tpa_pkg::MD_SUM;
            end
         end
         tpa_pkg::MD_SUM: begin
            acc_in   = {hi_ff[31:0], lo_ff} + {{32{rem_in[31]}}, rem_in};
            state_in = tpa_pkg::MD_ABS;
         end
         tpa_pkg::MD_ABS: begin
            neg_in   = acc_ff[63];
            acc_in   = acc_ff[63] ? (64'd0 - acc_ff) : acc_ff;
            r_in     = '0;
            cnt_in   = '0;
            state_in = tpa_pkg::MD_DIV;
         end
         tpa_pkg::MD_DIV: begin
            r_in   = ge ? (trial - den_eff) : trial;
            acc_in = {acc_ff[62:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               done_in  = 1'b1;
               state_in = tpa_pkg::MD_IDLE;
            end
         end
         default: state_in = tpa_pkg::MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpa_pkg::MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      r_ff   <= r_in;
   end

   assign done        = done_ff;
   assign result.quot = acc_ff;
   assign result.neg  = neg_ff;
   assign result.rem  = neg_ff ? (32'd0 - r_ff) : r_ff;

endmodule
`default_nettype wire

FILE: design/timeline_playhead_advance.sv
// ----------------------------------------------------------------------------
// timeline_playhead_advance
// Scales a source delta by a rational rate and walks a playhead over a
// timeline in once, loop or ping-pong mode, reporting traversed segments.
// ----------------------------------------------------------------------------
// Usage: one request carries a source delta on the req_ channel. The block
// answers on the rsp_ channel with one result per traversed segment, the
// final one marked by rsp_tlast, or with a single result when there is
// nothing to report or the request fails (rsp_tuser gives the status).
// One request is handled at a time; req_tready is high only when idle.
// Steps: a serial multiply, a sum and a sign fix-up, a serial division,
// then a dry walk over the segments and crossings that checks capacity,
// and a second walk that hands out the segments, one per cycle while the
// receiver takes them.
// A stalled receiver holds the output register and the second walk waits.
// Reset loads the register defaults, the playhead to zero, traversal one.
// The user must write registers through csr_ only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
module timeline_playhead_advance #(
   parameter int MAX_CROSSINGS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // [31:0] source_delta
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,   // seg_from, seg_to, seg_traversal,
                                          // seg_reverse, seg_include_from, pad
   output logic [2:0]        rsp_tuser,   // [0] seg_valid, [2:1] status
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   localparam int SEG_CAP = MAX_CROSSINGS + 2;
   localparam int CW      = $clog2(MAX_CROSSINGS + 2);
   localparam int NW      = $clog2(SEG_CAP + 1);

   tpa_pkg::state_type state_ff, state_in;

   // Configuration and architectural state.
   logic [31:0] dur_ff, dur_in;
   logic [1:0]  mode_ff, mode_in;
   logic [4:0]  mc_ff, mc_in;
   logic [31:0] num_ff, num_in;
   logic [30:0] den_ff, den_in;
   logic [31:0] play_ff, play_in;
   logic [31:0] trav_ff, trav_in;
   logic [31:0] rem_ff, rem_in;
   logic        rev_ff, rev_in;
   logic        primed_ff, primed_in;

   // Per-request values.
   logic [63:0]   q_ff, q_in;
   logic          sneg_ff, sneg_in;
   logic [31:0]   nrem_ff, nrem_in;
   logic [NW-1:0] ntot_ff, ntot_in;
   logic [1:0]    status_ff, status_in;

   // Walker.
   logic [31:0]   w_pos_ff, w_pos_in;
   logic [63:0]   w_mag_ff, w_mag_in;
   logic          w_down_ff, w_down_in;
   logic          w_rev_ff, w_rev_in;
   logic [31:0]   w_trav_ff, w_trav_in;
   logic          w_inc_ff, w_inc_in;
   logic [CW-1:0] w_cross_ff, w_cross_in;
   logic [NW-1:0] w_n_ff, w_n_in;
   logic          w_first_ff, w_first_in;
   logic          w_active_ff, w_active_in;

   // Output register.
   logic          rv_ff, rv_in;
   logic [31:0]   r_from_ff, r_from_in;
   logic [31:0]   r_to_ff, r_to_in;
   logic [31:0]   r_trav_ff, r_trav_in;
   logic          r_rev_ff, r_rev_in;
   logic          r_inc_ff, r_inc_in;
   logic          r_sv_ff, r_sv_in;
   logic [1:0]    r_status_ff, r_status_in;
   logic          r_last_ff, r_last_in;

   logic                   md_start, md_done;
   tpa_pkg::md_result_type md_res;

   tpa_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .delta  (req_tdata),
      .num    (num_ff),
      .rem_in (rem_ff),
      .den    (den_ff),
      .done   (md_done),
      .result (md_res)
   );

   // Walk step signals.
   logic          is_loop, is_pp;
   logic [CW-1:0] lim;
   logic [31:0]   span, bnd, near;
   logic          fits;
   logic          seg_emit, seg_rev, seg_inc;
   logic [31:0]   seg_to;
   logic          wk_err, wk_end;
   logic [CW-1:0] cross_next;
   logic [31:0]   wk_pos;
   logic [63:0]   wk_mag;
   logic          wk_down, wk_rev, wk_inc, wk_active, wk_first;
   logic [31:0]   wk_trav;
   logic [CW-1:0] wk_cross;
   logic [NW-1:0] wk_n;
   logic          slot_free;

   always_comb begin
      is_loop    = mode_ff == tpa_pkg::MODE_LOOP;
      is_pp      = mode_ff == tpa_pkg::MODE_PINGPONG;
      lim        = (32'(mc_ff) > 32'(MAX_CROSSINGS)) ? CW'(MAX_CROSSINGS) : CW'(mc_ff);
      span       = w_down_ff ? w_pos_ff : (dur_ff - w_pos_ff);
      bnd        = w_down_ff ? 32'd0 : dur_ff;
      near       = w_down_ff ? (w_pos_ff - w_mag_ff[31:0]) : (w_pos_ff + w_mag_ff[31:0]);
      fits       = (w_mag_ff[63:32] == 32'd0) && (w_mag_ff[31:0] <= span);
      cross_next = w_cross_ff + CW'(1);
      wk_end     = !w_first_ff && !w_active_ff;

      seg_emit  = 1'b0;
      seg_to    = w_pos_ff;
      seg_rev   = w_down_ff;
      seg_inc   = 1'b0;
      wk_err    = 1'b0;
      wk_pos    = w_pos_ff;
      wk_mag    = w_mag_ff;
      wk_down   = w_down_ff;
      wk_rev    = w_rev_ff;
      wk_inc    = w_inc_ff;
      wk_active = w_active_ff;
      wk_first  = w_first_ff;
      wk_trav   = w_trav_ff;
      wk_cross  = w_cross_ff;

      if (w_first_ff) begin
         // Zero-length segment on the starting point.
         seg_emit = 1'b1;
         seg_rev  = sneg_ff;
         seg_inc  = 1'b1;
         wk_first = 1'b0;
      end else if (w_active_ff) begin
         seg_inc = is_loop & w_inc_ff;
         if (!is_loop && !is_pp) begin
            seg_emit  = 1'b1;
            seg_to    = fits ? near : bnd;
            wk_pos    = seg_to;
            wk_active = 1'b0;
         end else if (fits) begin
            seg_emit  = 1'b1;
            seg_to    = near;
            wk_pos    = near;
            wk_active = 1'b0;
         end else begin
            // Runs past the end: go to the boundary and cross it.
            seg_emit = span != 32'd0;
            seg_to   = bnd;
            wk_mag   = w_mag_ff - {32'd0, span};
            wk_cross = cross_next;
            wk_err   = (cross_next > lim) || (w_trav_ff == 32'hFFFF_FFFF);
            wk_trav  = w_trav_ff + 32'd1;
            if (is_loop) begin
               wk_pos = w_down_ff ? dur_ff : 32'd0;
               wk_inc = 1'b1;
            end else begin
               wk_pos  = bnd;
               wk_down = !w_down_ff;
               wk_rev  = !w_rev_ff;
            end
         end
      end
      if (seg_emit && (32'(w_n_ff) == 32'(SEG_CAP))) begin
         wk_err = 1'b1;
      end
      wk_n = seg_emit ? (w_n_ff + NW'(1)) : w_n_ff;
   end

   always_comb begin
      slot_free = !rv_ff || rsp_tready;

      state_in  = state_ff;
      req_tready = 1'b0;
      md_start  = 1'b0;

      dur_in    = dur_ff;
      mode_in   = mode_ff;
      mc_in     = mc_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      play_in   = play_ff;
      trav_in   = trav_ff;
      rem_in    = rem_ff;
      rev_in    = rev_ff;
      primed_in = primed_ff;

      q_in      = q_ff;
      sneg_in   = sneg_ff;
      nrem_in   = nrem_ff;
      ntot_in   = ntot_ff;
      status_in = status_ff;

      w_pos_in    = w_pos_ff;
      w_mag_in    = w_mag_ff;
      w_down_in   = w_down_ff;
      w_rev_in    = w_rev_ff;
      w_trav_in   = w_trav_ff;
      w_inc_in    = w_inc_ff;
      w_cross_in  = w_cross_ff;
      w_n_in      = w_n_ff;
      w_first_in  = w_first_ff;
      w_active_in = w_active_ff;

      rv_in       = rsp_tready ? 1'b0 : rv_ff;
      r_from_in   = r_from_ff;
      r_to_in     = r_to_ff;
      r_trav_in   = r_trav_ff;
      r_rev_in    = r_rev_ff;
      r_inc_in    = r_inc_ff;
      r_sv_in     = r_sv_ff;
      r_status_in = r_status_ff;
      r_last_in   = r_last_ff;

      unique case (state_ff)
         tpa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tdata[31]) begin
                  status_in = tpa_pkg::STATUS_NEG;
                  state_in  = tpa_pkg::ST_SINGLE;
               end else begin
                  md_start = 1'b1;
                  state_in = tpa_pkg::ST_CALC;
               end
            end
         end
         tpa_pkg::ST_CALC: begin
            if (md_done) begin
               q_in        = md_res.quot;
               sneg_in     = md_res.neg && (md_res.quot != 64'd0);
               nrem_in     = md_res.rem;
               w_pos_in    = play_ff;
               w_mag_in    = md_res.quot;
               w_down_in   = (md_res.neg && (md_res.quot != 64'd0)) ^ (is_pp & rev_ff);
               w_rev_in    = rev_ff;
               w_trav_in   = trav_ff;
               w_inc_in    = 1'b0;
               w_cross_in  = '0;
               w_n_in      = '0;
               w_first_in  = !primed_ff;
               w_active_in = md_res.quot != 64'd0;
               state_in    = tpa_pkg::ST_DRY;
            end
         end
         tpa_pkg::ST_DRY: begin
            if (wk_end) begin
               ntot_in = w_n_ff;
               if (w_n_ff == '0) begin
                  rem_in    = nrem_ff;
                  primed_in = 1'b1;
                  status_in = tpa_pkg::STATUS_OK;
                  state_in  = tpa_pkg::ST_SINGLE;
               end else begin
                  // Second pass from the same starting state hands out segments.
                  w_pos_in    = play_ff;
                  w_mag_in    = q_ff;
                  w_down_in   = sneg_ff ^ (is_pp & rev_ff);
                  w_rev_in    = rev_ff;
                  w_trav_in   = trav_ff;
                  w_inc_in    = 1'b0;
                  w_cross_in  = '0;
                  w_n_in      = '0;
                  w_first_in  = !primed_ff;
                  w_active_in = q_ff != 64'd0;
                  state_in    = tpa_pkg::ST_EMIT;
               end
            end else if (wk_err) begin
               status_in = tpa_pkg::STATUS_CAP;
               state_in  = tpa_pkg::ST_SINGLE;
            end else begin
               w_pos_in    = wk_pos;
               w_mag_in    = wk_mag;
               w_down_in   = wk_down;
               w_rev_in    = wk_rev;
               w_trav_in   = wk_trav;
               w_inc_in    = wk_inc;
               w_cross_in  = wk_cross;
               w_n_in      = wk_n;
               w_first_in  = wk_first;
               w_active_in = wk_active;
            end
         end
         tpa_pkg::ST_EMIT: begin
            if (wk_end) begin
               play_in   = w_pos_ff;
               trav_in   = w_trav_ff;
               rem_in    = nrem_ff;
               rev_in    = w_rev_ff;
               primed_in = 1'b1;
               state_in  = tpa_pkg::ST_IDLE;
            end else if (!seg_emit || slot_free) begin
               w_pos_in    = wk_pos;
               w_mag_in    = wk_mag;
               w_down_in   = wk_down;
               w_rev_in    = wk_rev;
               w_trav_in   = wk_trav;
               w_inc_in    = wk_inc;
               w_cross_in  = wk_cross;
               w_n_in      = wk_n;
               w_first_in  = wk_first;
               w_active_in = wk_active;
               if (seg_emit) begin
                  rv_in       = 1'b1;
                  r_from_in   = w_pos_ff;
                  r_to_in     = seg_to;
                  r_trav_in   = w_trav_ff;
                  r_rev_in    = seg_rev;
                  r_inc_in    = seg_inc;
                  r_sv_in     = 1'b1;
                  r_status_in = tpa_pkg::STATUS_OK;
                  r_last_in   = wk_n == ntot_ff;
               end
            end
         end
         tpa_pkg::ST_SINGLE: begin
            if (slot_free) begin
               rv_in       = 1'b1;
               r_from_in   = '0;
               r_to_in     = '0;
               r_trav_in   = '0;
               r_rev_in    = 1'b0;
               r_inc_in    = 1'b0;
               r_sv_in     = 1'b0;
               r_status_in = status_ff;
               r_last_in   = 1'b1;
               state_in    = tpa_pkg::ST_IDLE;
            end
         end
         default: state_in = tpa_pkg::ST_IDLE;
      endcase

      if (csr_we) begin
         unique case (csr_index)
            tpa_pkg::REG_DURATION: begin
               dur_in = csr_wdata;
               if (play_ff > csr_wdata) begin
                  play_in = csr_wdata;
               end
            end
            tpa_pkg::REG_LOOP_MODE: mode_in = csr_wdata[1:0];
            tpa_pkg::REG_MAX_CROSS: mc_in = csr_wdata[4:0];
            tpa_pkg::REG_RATE_NUM:  num_in = csr_wdata;
            tpa_pkg::REG_RATE_DEN: begin
               den_in = csr_wdata[30:0];
               rem_in = '0;
            end
            tpa_pkg::REG_START_POS: begin
               play_in = (csr_wdata > dur_ff) ? dur_ff : csr_wdata;
            end
            tpa_pkg::REG_SUPPRESS: primed_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tpa_pkg::ST_IDLE;
         rv_ff     <= 1'b0;
         dur_ff    <= 32'd1;
         mode_ff   <= 2'd0;
         mc_ff     <= 5'd1;
         num_ff    <= 32'd1;
         den_ff    <= 31'd1;
         play_ff   <= 32'd0;
         trav_ff   <= 32'd1;
         rem_ff    <= 32'd0;
         rev_ff    <= 1'b0;
         primed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rv_ff     <= rv_in;
         dur_ff    <= dur_in;
         mode_ff   <= mode_in;
         mc_ff     <= mc_in;
         num_ff    <= num_in;
         den_ff    <= den_in;
         play_ff   <= play_in;
         trav_ff   <= trav_in;
         rem_ff    <= rem_in;
         rev_ff    <= rev_in;
         primed_ff <= primed_in;
      end
      q_ff        <= q_in;
      sneg_ff     <= sneg_in;
      nrem_ff     <= nrem_in;
      ntot_ff     <= ntot_in;
      status_ff   <= status_in;
      w_pos_ff    <= w_pos_in;
      w_mag_ff    <= w_mag_in;
      w_down_ff   <= w_down_in;
      w_rev_ff    <= w_rev_in;
      w_trav_ff   <= w_trav_in;
      w_inc_ff    <= w_inc_in;
      w_cross_ff  <= w_cross_in;
      w_n_ff      <= w_n_in;
      w_first_ff  <= w_first_in;
      w_active_ff <= w_active_in;
      r_from_ff   <= r_from_in;
      r_to_ff     <= r_to_in;
      r_trav_ff   <= r_trav_in;
      r_rev_ff    <= r_rev_in;
      r_inc_ff    <= r_inc_in;
      r_sv_ff     <= r_sv_in;
      r_status_ff <= r_status_in;
      r_last_ff   <= r_last_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {6'd0, r_inc_ff, r_rev_ff, r_trav_ff, r_to_ff, r_from_ff};
   assign rsp_tuser  = {r_status_ff, r_sv_ff};
   assign rsp_tlast  = r_last_ff;

   // An empty or failed result always closes its request.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("empty or error result without last");

   // The playhead never leaves the timeline.
   a_play_range: assert property (@(posedge clock) disable iff (reset)
      play_ff <= dur_ff)
      else $error("playhead beyond duration");

   // The delivery pass never hands out more segments than the check pass counted.
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == tpa_pkg::ST_EMIT && seg_emit |-> w_n_ff < ntot_ff)
      else $error("segment count exceeds checked total");

endmodule
`default_nettype wire

FILE: test/timeline_playhead_advance_test.sv
// ----------------------------------------------------------------------------
// timeline_playhead_advance_test
// Drives source deltas into the playhead block under once, loop and ping-pong
// settings, predicts every traversed segment in a behavioural copy of the
// playhead and checks each result field by field, with random idling on both
// channels, one long receiver stall and register changes between phases.
// ----------------------------------------------------------------------------
`default_nettype none
module timeline_playhead_advance_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEG_CAP    = 18;
   localparam int CROSS_CAP  = 16;
   localparam int CYCLE_STOP = 600000;

   typedef struct {
      logic [31:0] from_pos;
      logic [31:0] to_pos;
      logic [31:0] traversal;
      bit          reverse;
      bit          include_from;
      bit          valid;
      logic [1:0]  status;
      bit          last;
   } segment_type;

   typedef struct {
      bit          is_write;
      logic [2:0]  index;
      logic [31:0] value;
      bit          typed;
      segment_type result;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   timeline_playhead_advance u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Playhead copy: registers and state.
   logic [31:0] ph_duration, ph_mode, ph_max_cross, ph_num, ph_den, ph_start;
   logic [31:0] ph_position, ph_traversal, ph_remainder;
   bit          ph_reversed, ph_primed;

   segment_type expected_segments[$];
   segment_type staged[$];
   segment_type step_results[$];

   int  error_count = 0;
   int  requests_sent = 0;
   int  segments_seen = 0;
   int  hold_cycles = 0;
   bit  no_gaps = 1'b0;
   int  cycle_count = 0;

   function automatic segment_type single_result(logic [1:0] status);
      segment_type s;
      s = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, status, 1'b1};
      return s;
   endfunction

   function automatic bit stage_segment(longint f, longint t, logic [31:0] tr,
                                        bit rv, bit inc);
      if (staged.size() >= SEG_CAP)
         return 1'b0;
      staged.push_back('{f[31:0], t[31:0], tr, rv, inc, 1'b1, tpa_pkg::STATUS_OK, 1'b0});
      return 1'b1;
   endfunction

   function automatic void apply_register(logic [2:0] idx, logic [31:0] v);
      case (idx)
         tpa_pkg::REG_DURATION: begin
            ph_duration = v;
            if (ph_position > ph_duration)
               ph_position = ph_duration;
         end
         tpa_pkg::REG_LOOP_MODE: ph_mode = v & 32'd3;
         tpa_pkg::REG_MAX_CROSS: ph_max_cross = v & 32'd31;
         tpa_pkg::REG_RATE_NUM: ph_num = v;
         tpa_pkg::REG_RATE_DEN: begin
            ph_den = v & 32'h7fffffff;
            ph_remainder = '0;
         end
         tpa_pkg::REG_START_POS: begin
            ph_start = v;
            ph_position = (ph_start > ph_duration) ? ph_duration : ph_start;
         end
         tpa_pkg::REG_SUPPRESS: ph_primed = v[0];
         default: ;
      endcase
   endfunction

   // Works out the results of one request into step_results and moves the
   // playhead, unless the request fails.
   function automatic void advance_playhead(logic [31:0] d);
      longint delta, dur, den, scaled, stp, new_rem, pos, remaining, span, mag, nxt;
      logic [31:0] trav, limit, crossings;
      bit rv, primed, ok, inc, fwd, down;
      step_results.delete();
      staged.delete();
      delta = longint'(signed'(d));
      if (delta < 0) begin
         step_results.push_back(single_result(tpa_pkg::STATUS_NEG));
         return;
      end
      dur = longint'(ph_duration);
      den = (ph_den == 0) ? 1 : longint'(ph_den);
      pos = longint'(ph_position);
      trav = ph_traversal;
      limit = (ph_max_cross > CROSS_CAP) ? CROSS_CAP : ph_max_cross;
      crossings = 0;
      rv = ph_reversed;
      primed = ph_primed;
      ok = 1'b1;
      scaled = delta * longint'(signed'(ph_num)) + longint'(signed'(ph_remainder));
      stp = scaled / den;
      new_rem = scaled % den;
      if (!primed) begin
         ok = stage_segment(pos, pos, trav, stp < 0, 1'b1);
         primed = 1'b1;
      end
      if (ok && stp != 0) begin
         if (ph_mode[1:0] == tpa_pkg::MODE_LOOP) begin
            remaining = stp;
            inc = 1'b0;
            while (ok && remaining != 0) begin
               fwd = remaining > 0;
               span = fwd ? dur - pos : pos;
               mag = fwd ? remaining : -remaining;
               if (mag <= span) begin
                  ok = stage_segment(pos, pos + remaining, trav, !fwd, inc);
                  pos += remaining;
                  break;
               end
               if (span > 0) begin
                  nxt = fwd ? dur : 0;
                  ok = stage_segment(pos, nxt, trav, !fwd, inc);
                  pos = nxt;
                  remaining += fwd ? -span : span;
               end
               if (!ok)
                  break;
               crossings++;
               if (crossings > limit || trav == 32'hffffffff) begin
                  ok = 1'b0;
                  break;
               end
               trav++;
               pos = fwd ? 0 : dur;
               inc = 1'b1;
            end
         end else if (ph_mode[1:0] == tpa_pkg::MODE_PINGPONG) begin
            remaining = (stp < 0) ? -stp : stp;
            down = (stp < 0) ? !rv : rv;
            while (ok && remaining != 0) begin
               span = down ? pos : dur - pos;
               if (remaining <= span) begin
                  nxt = down ? pos - remaining : pos + remaining;
                  ok = stage_segment(pos, nxt, trav, down, 1'b0);
                  pos = nxt;
                  break;
               end
               if (span > 0) begin
                  nxt = down ? 0 : dur;
                  ok = stage_segment(pos, nxt, trav, down, 1'b0);
                  pos = nxt;
                  remaining -= span;
               end
               if (!ok)
                  break;
               crossings++;
               if (crossings > limit || trav == 32'hffffffff) begin
                  ok = 1'b0;
                  break;
               end
               trav++;
               down = !down;
               rv = !rv;
            end
         end else begin
            if (stp > 0)
               nxt = (stp > dur - pos) ? dur : pos + stp;
            else
               nxt = (-stp > pos) ? 0 : pos + stp;
            ok = stage_segment(pos, nxt, trav, stp < 0, 1'b0);
            pos = nxt;
         end
      end
      if (!ok) begin
         step_results.push_back(single_result(tpa_pkg::STATUS_CAP));
         return;
      end
      ph_position = pos[31:0];
      ph_traversal = trav;
      ph_remainder = new_rem[31:0];
      ph_reversed = rv;
      ph_primed = primed;
      if (staged.size() == 0) begin
         step_results.push_back(single_result(tpa_pkg::STATUS_OK));
         return;
      end
      staged[staged.size() - 1].last = 1'b1;
      step_results = staged;
   endfunction

   task automatic wait_until_idle();
      while (expected_segments.size() != 0)
         @(negedge clock);
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      apply_register(idx, v);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Offers one request, waits for the edge where it is taken and withdraws
   // it at the next falling edge. With a typed expectation the prediction
   // still moves the playhead copy.
   task automatic send_request(logic [31:0] d, bit typed, segment_type typed_result);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = d;
      do @(posedge clock); while (!req_tready);
      advance_playhead(d);
      if (typed)
         expected_segments.push_back(typed_result);
      else
         foreach (step_results[i])
            expected_segments.push_back(step_results[i]);
      requests_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Receiver: checks at the rising edge, changes tready at the falling edge.
   initial begin : receiver
      int gap;
      segment_type want, got;
      gap = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[96],
                    rsp_tdata[97], rsp_tuser[0], rsp_tuser[2:1], rsp_tlast};
            segments_seen++;
            if (expected_segments.size() == 0) begin
               $error("unexpected result: from %0d to %0d", got.from_pos, got.to_pos);
               error_count++;
            end else begin
               want = expected_segments.pop_front();
               if (got.from_pos !== want.from_pos) begin
                  $error("seg_from: expected %0d, got %0d", want.from_pos, got.from_pos);
                  error_count++;
               end
               if (got.to_pos !== want.to_pos) begin
                  $error("seg_to: expected %0d, got %0d", want.to_pos, got.to_pos);
                  error_count++;
               end
               if (got.traversal !== want.traversal) begin
                  $error("seg_traversal: expected %0d, got %0d",
                         want.traversal, got.traversal);
                  error_count++;
               end
               if (got.reverse !== want.reverse) begin
                  $error("seg_reverse: expected %0d, got %0d", want.reverse, got.reverse);
                  error_count++;
               end
               if (got.include_from !== want.include_from) begin
                  $error("seg_include_from: expected %0d, got %0d",
                         want.include_from, got.include_from);
                  error_count++;
               end
               if (got.valid !== want.valid) begin
                  $error("seg_valid: expected %0d, got %0d", want.valid, got.valid);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  error_count++;
               end
            end
            gap = no_gaps ? 0 : $urandom_range(0, 5);
         end
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready = 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_STOP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic plan_row_type reg_row(logic [2:0] idx, logic [31:0] v);
      plan_row_type r;
      r = '{1'b1, idx, v, 1'b0, single_result(tpa_pkg::STATUS_OK)};
      return r;
   endfunction

   function automatic plan_row_type delta_row(logic [31:0] d);
      plan_row_type r;
      r = '{1'b0, tpa_pkg::REG_DURATION, d, 1'b0, single_result(tpa_pkg::STATUS_OK)};
      return r;
   endfunction

   function automatic plan_row_type typed_row(logic [31:0] d, segment_type s);
      plan_row_type r;
      r = '{1'b0, tpa_pkg::REG_DURATION, d, 1'b1, s};
      return r;
   endfunction

   initial begin : stimulus
      plan_row_type plan[$];
      logic [31:0] d;
      int pick;
      ph_duration = 1; ph_mode = 0; ph_max_cross = 1; ph_num = 1; ph_den = 1;
      ph_start = 0; ph_position = 0; ph_traversal = 1; ph_remainder = 0;
      ph_reversed = 0; ph_primed = 0;

      // After reset: the boundary segment at zero, one step to the end, then
      // the most negative delta.
      plan.push_back(typed_row(32'd0,
         '{32'd0, 32'd0, 32'd1, 1'b0, 1'b1, 1'b1, tpa_pkg::STATUS_OK, 1'b1}));
      plan.push_back(typed_row(32'd1,
         '{32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b1, tpa_pkg::STATUS_OK, 1'b1}));
      plan.push_back(typed_row(32'h80000000, single_result(tpa_pkg::STATUS_NEG)));
      plan.push_back(delta_row(32'd5));
      plan.push_back(reg_row(tpa_pkg::REG_DURATION, 32'd100));
      plan.push_back(reg_row(tpa_pkg::REG_LOOP_MODE, 32'(tpa_pkg::MODE_LOOP)));
      plan.push_back(reg_row(tpa_pkg::REG_MAX_CROSS, 32'd16));
      plan.push_back(reg_row(tpa_pkg::REG_RATE_NUM, 32'd7));
      plan.push_back(reg_row(tpa_pkg::REG_RATE_DEN, 32'd3));
      plan.push_back(delta_row(32'd50));
      plan.push_back(typed_row(32'd1000, single_result(tpa_pkg::STATUS_CAP)));
      plan.push_back(delta_row(32'd200));
      plan.push_back(typed_row(32'h7fffffff, single_result(tpa_pkg::STATUS_CAP)));
      plan.push_back(reg_row(tpa_pkg::REG_LOOP_MODE, 32'(tpa_pkg::MODE_PINGPONG)));
      plan.push_back(reg_row(tpa_pkg::REG_RATE_NUM, 32'hffffffff));
      plan.push_back(reg_row(tpa_pkg::REG_RATE_DEN, 32'd1));
      plan.push_back(delta_row(32'd30));
      plan.push_back(delta_row(32'd250));
      plan.push_back(delta_row(32'd0));
      // No crossing allowed at all.
      plan.push_back(reg_row(tpa_pkg::REG_MAX_CROSS, 32'd0));
      plan.push_back(delta_row(32'd500));
      // Mode three behaves as once; extreme rate.
      plan.push_back(reg_row(tpa_pkg::REG_LOOP_MODE, 32'd3));
      plan.push_back(reg_row(tpa_pkg::REG_RATE_NUM, 32'h80000000));
      plan.push_back(reg_row(tpa_pkg::REG_RATE_DEN, 32'h7fffffff));
      plan.push_back(delta_row(32'h7fffffff));
      plan.push_back(delta_row(32'd1));
      // Zero duration in loop mode crosses on every step.
      plan.push_back(reg_row(tpa_pkg::REG_DURATION, 32'd0));
      plan.push_back(reg_row(tpa_pkg::REG_LOOP_MODE, 32'(tpa_pkg::MODE_LOOP)));
      plan.push_back(delta_row(32'd1));
      plan.push_back(reg_row(tpa_pkg::REG_DURATION, 32'hffffffff));
      plan.push_back(reg_row(tpa_pkg::REG_START_POS, 32'hffffffff));
      plan.push_back(reg_row(tpa_pkg::REG_SUPPRESS, 32'd1));
      plan.push_back(reg_row(tpa_pkg::REG_LOOP_MODE, 32'(tpa_pkg::MODE_PINGPONG)));
      plan.push_back(reg_row(tpa_pkg::REG_MAX_CROSS, 32'd31));
      plan.push_back(reg_row(tpa_pkg::REG_RATE_NUM, 32'd1));
      plan.push_back(reg_row(tpa_pkg::REG_RATE_DEN, 32'd1));
      plan.push_back(delta_row(32'h7fffffff));
      // A zero denominator acts as one.
      plan.push_back(reg_row(tpa_pkg::REG_RATE_DEN, 32'd0));
      plan.push_back(reg_row(tpa_pkg::REG_SUPPRESS, 32'd0));
      plan.push_back(delta_row(32'd3));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            if (i == 0 || !plan[i - 1].is_write)
               wait_until_idle();
            write_register(plan[i].index, plan[i].value);
         end else begin
            send_request(plan[i].value, plan[i].typed, plan[i].result);
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         wait_until_idle();
         @(negedge clock);
         req_tvalid = 1'b0;
         pick = $urandom_range(0, 9);
         write_register(tpa_pkg::REG_DURATION,
                        (pick == 0) ? $urandom : $urandom_range(1, 50));
         write_register(tpa_pkg::REG_LOOP_MODE, $urandom_range(0, 3));
         write_register(tpa_pkg::REG_MAX_CROSS, $urandom_range(0, 31));
         write_register(tpa_pkg::REG_RATE_NUM,
                        (pick == 1) ? $urandom : $urandom_range(0, 80) - 40);
         write_register(tpa_pkg::REG_RATE_DEN,
                        (pick == 2) ? $urandom : $urandom_range(1, 10));
         write_register(tpa_pkg::REG_START_POS, $urandom_range(0, 60));
         write_register(tpa_pkg::REG_SUPPRESS, $urandom_range(0, 1));
         no_gaps = (phase == 2);
         // The receiver stalls for long while requests keep being offered.
         if (phase == 1)
            hold_cycles = 400;
         for (int k = 0; k < 14; k++) begin
            // In the last phase the sender lets every result drain first.
            if (phase == 5)
               while (expected_segments.size() != 0)
                  @(negedge clock);
            pick = $urandom_range(0, 19);
            if (pick < 2)
               d = $urandom | 32'h80000000;
            else if (pick < 4)
               d = $urandom;
            else
               d = $urandom_range(0, 40);
            send_request(d, 1'b0, single_result(tpa_pkg::STATUS_OK));
         end
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      while (expected_segments.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d requests over once, loop and ping-pong settings;", requests_sent);
      $display("checked %0d results, with stalls on both channels.", segments_seen);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
design/tpa_pkg.sv
design/tpa_muldiv.sv
design/timeline_playhead_advance.sv
test/timeline_playhead_advance_test.sv
